[rtl/posix_cksum_crc32_macros.svh]
// ----------------------------------------------------------------------------
// posix_cksum_crc32 assertion macros
// Concurrent assertion wrappers on clk / arst_n; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef POSIX_CKSUM_CRC32_MACROS_SVH
`define POSIX_CKSUM_CRC32_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define CKC_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ckc assertion failed");
// checked on every edge, reset included
`define CKC_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("ckc assertion failed");
`else
`define CKC_ASSERT(name, prop)
`define CKC_ASSERT_ALWAYS(name, prop)
`endif
`endif

[rtl/ckc_pkg.sv]
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types, constants and the CRC byte step for the cksum engine.
// ----------------------------------------------------------------------------
package ckc_pkg;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// one queued request
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        last;
		logic [31:0] expected_sum;
	} ckc_req_t;

	// queue status seen by the back end
	typedef struct packed {
		logic     valid;
		ckc_req_t head;
	} ckc_q_t;

	// MSB-first CRC-32 update by one byte
	function automatic logic [31:0] crc_absorb(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h0};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[rtl/ckc_if.sv]
// ----------------------------------------------------------------------------
// ckc channel interfaces
// Valid/ready channels for message requests and checksum results.
// ----------------------------------------------------------------------------
interface ckc_msg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        last;
	logic [31:0] expected_sum;

	modport source (output valid, data_byte, has_byte, last, expected_sum, input ready);
	modport sink   (input valid, data_byte, has_byte, last, expected_sum, output ready);
endinterface

interface ckc_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] sum;
	logic        sum_matches;

	modport source (output valid, sum, sum_matches, input ready);
	modport sink   (input valid, sum, sum_matches, output ready);
endinterface

[rtl/ckc_fifo.sv]
// ----------------------------------------------------------------------------
// ckc_fifo
// Short request queue between front and back end.
// ----------------------------------------------------------------------------
module ckc_fifo import ckc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ckc_req_t push_req,
	output logic     full,
	input  logic     pop,
	output ckc_q_t   q
);

	ckc_req_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full    = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign q.valid = (fill_q != '0);
	assign q.head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/ckc_front.sv]
// ----------------------------------------------------------------------------
// ckc_front
// Takes message requests, drops empty ones, queues the rest.
// ----------------------------------------------------------------------------
module ckc_front import ckc_pkg::*; (
	ckc_msg_if.sink  msg,
	input  logic     full,
	output logic     push,
	output ckc_req_t push_req
);

	// a request with neither byte nor end mark has no effect
	logic useful;

	assign useful    = msg.has_byte | msg.last;
	assign msg.ready = !full;
	assign push      = msg.valid & !full & useful;

	assign push_req.data_byte    = msg.data_byte;
	assign push_req.has_byte     = msg.has_byte;
	assign push_req.last         = msg.last;
	assign push_req.expected_sum = msg.expected_sum;

endmodule

[rtl/ckc_back.sv]
// ----------------------------------------------------------------------------
// ckc_back
// CRC register, byte counter, length fold and result register.
// ----------------------------------------------------------------------------
`include "posix_cksum_crc32_macros.svh"

module ckc_back import ckc_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ckc_q_t    q,
	output logic      pop,
	ckc_res_if.source res
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_FOLD = 2'b10
	} st_t;

	st_t                   state_q;
	logic [31:0]           crc_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [31:0]           exp_q;
	logic                  valid_q;
	logic [31:0]           sum_q;
	logic                  match_q;

	logic [31:0]           byte_crc;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  out_free;
	logic                  load;

	assign pop      = (state_q == ST_IDLE) & q.valid;
	assign byte_crc = crc_absorb(crc_q, q.head.data_byte);
	assign cnt_inc  = (count_q == '1) ? count_q : count_q + 1'b1;   // saturate
	assign out_free = !valid_q | res.ready;
	assign load     = (state_q == ST_FOLD) & (n_q == '0) & out_free;

	assign res.valid       = valid_q;
	assign res.sum         = sum_q;
	assign res.sum_matches = match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			crc_q   <= '0;
			count_q <= '0;
			n_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (q.head.has_byte) begin
							crc_q <= byte_crc;
						end
						if (q.head.last) begin
							n_q     <= q.head.has_byte ? cnt_inc : count_q;
							count_q <= '0;
							state_q <= ST_FOLD;
						end else if (q.head.has_byte) begin
							count_q <= cnt_inc;
						end
					end
				end
				ST_FOLD: begin
					// length goes in low byte first, stop when nothing left
					if (n_q != '0) begin
						crc_q <= crc_absorb(crc_q, n_q[7:0]);
						n_q   <= n_q >> 8;
					end else if (out_free) begin
						crc_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload and expected value
	always_ff @(posedge clk) begin
		if (pop && q.head.last) begin
			exp_q <= q.head.expected_sum;
		end
		if (load) begin
			sum_q   <= ~crc_q;
			match_q <= (~crc_q == exp_q);
		end
	end

	`CKC_ASSERT(a_fold_count_clear, (state_q == ST_FOLD) |-> (count_q == '0))
	`CKC_ASSERT(a_fold_shift, (state_q == ST_FOLD && n_q != '0) |=> (n_q == ($past(n_q) >> 8)))
	`CKC_ASSERT(a_load_clears, load |=> (valid_q && crc_q == '0 && state_q == ST_IDLE))

endmodule

[rtl/posix_cksum_crc32.sv]
// ----------------------------------------------------------------------------
// posix_cksum_crc32
// POSIX cksum engine: CRC-32 over a byte stream with length fold.
// ----------------------------------------------------------------------------
// Usage:
//   msg : one request per message byte (has_byte = 1); the request with
//         last = 1 ends the message and may carry a byte or be a bare end
//         mark. expected_sum is sampled from the last request only.
//         Requests with neither has_byte nor last are taken and dropped.
//   res : one result per message: sum (inverted CRC after length fold)
//         and sum_matches (sum == expected_sum).
// Throughput: one byte request per cycle while the queue has room, sustained
//   through a two-entry queue in front of the CRC unit. At message end the
//   CRC unit absorbs each significant byte of the length (0..COUNT_BITS/8),
//   then loads the result register; bytes behind it wait in the queue.
// Reset: arst_n clears the queue, CRC, count and result valid at once.
// Stall: a held result blocks only the next message end; bytes of the
//   following message keep flowing until the queue fills, then msg.ready
//   drops.
// ----------------------------------------------------------------------------
module posix_cksum_crc32 import ckc_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	ckc_msg_if.sink   msg,
	ckc_res_if.source res
);

	logic     push;
	ckc_req_t push_req;
	logic     full;
	logic     pop;
	ckc_q_t   q;

	// front: accept and filter requests
	ckc_front u_front (
		.msg      (msg),
		.full     (full),
		.push     (push),
		.push_req (push_req)
	);

	// decoupling queue
	ckc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.full     (full),
		.pop      (pop),
		.q        (q)
	);

	// back: CRC, count, length fold, result register
	ckc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q      (q),
		.pop    (pop),
		.res    (res)
	);

endmodule
